// ===== hw/rtl/frf_pkg.sv =====
// Package for the Fresnel reflectance pipeline: payload structs, fixed-point
// constants, stage counts and the one-step functions of the iterative units.
// No dependencies.
`default_nettype none

package frf_pkg;

    localparam int COMP_W     = 16;
    localparam int COMP_FRAC  = COMP_W - 2;
    localparam int PROD_W     = 2 * COMP_W;
    localparam int PROD_SHIFT = 30 - 2 * COMP_FRAC;
    localparam int DOT_W      = PROD_W + PROD_SHIFT + 2;

    localparam logic [15:0] ONE_Q12  = 16'd4096;
    localparam logic [15:0] REFL_ONE = 16'd32768;
    localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
    localparam logic [30:0] ONE_Q30  = 31'd1 << 30;

    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = 32 / STEPS_PER_STAGE;
    localparam int DIV_STAGES      = 30 / STEPS_PER_STAGE;
    localparam int FRAC_STAGES     = 30 / STEPS_PER_STAGE;
    localparam int LATENCY = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1 + SQRT_STAGES + 2
                             + FRAC_STAGES + 2;

    typedef struct packed {
        logic signed [15:0] incident_x;
        logic signed [15:0] incident_y;
        logic signed [15:0] incident_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        index_ratio;
    } fr_in_t;

    typedef struct packed {
        logic [15:0] reflectance;
        logic        total_internal;
        logic        bad_index;
    } fr_out_t;

    // Per-item data that rides alongside the arithmetic units.
    typedef struct packed {
        logic [30:0] c;
        logic [15:0] ei;
        logic [15:0] et;
        logic        bad;
        logic        tir;
    } side_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_state_t;

    typedef struct packed {
        logic [29:0] num;
        logic [15:0] rem;
        logic [29:0] q;
    } div_state_t;

    typedef struct packed {
        logic [46:0] r;
        logic [46:0] d;
        logic [29:0] q;
        logic        one;
    } frac_state_t;

    // One digit of a restoring square root, two radicand bits per digit.
    function automatic sq_state_t sqrt_step(sq_state_t s);
        logic [33:0] rem2;
        logic [33:0] trial;
        sq_state_t n;
        rem2  = {s.rem[31:0], s.rad[63:62]};
        trial = {s.root, 2'b01};
        n.rad = {s.rad[61:0], 2'b00};
        if (rem2 >= trial)
        begin
            n.rem  = rem2 - trial;
            n.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            n.rem  = rem2;
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

    // One quotient bit of a restoring division by a 16-bit divisor.
    function automatic div_state_t div_step(div_state_t s, logic [15:0] d);
        logic [16:0] rem2;
        logic [16:0] diff;
        div_state_t n;
        rem2  = {s.rem, s.num[29]};
        diff  = rem2 - {1'b0, d};
        n.num = {s.num[28:0], 1'b0};
        if (rem2 >= {1'b0, d})
        begin
            n.rem = diff[15:0];
            n.q   = {s.q[28:0], 1'b1};
        end
        else
        begin
            n.rem = rem2[15:0];
            n.q   = {s.q[28:0], 1'b0};
        end
        return n;
    endfunction

    // One bit of a fractional quotient n/d with n < d.
    function automatic frac_state_t frac_step(frac_state_t s);
        logic [47:0] r2;
        logic [47:0] diff;
        frac_state_t n;
        r2    = {s.r, 1'b0};
        diff  = r2 - {1'b0, s.d};
        n.d   = s.d;
        n.one = s.one;
        if (r2 >= {1'b0, s.d})
        begin
            n.r = diff[46:0];
            n.q = {s.q[28:0], 1'b1};
        end
        else
        begin
            n.r = r2[46:0];
            n.q = {s.q[28:0], 1'b0};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frf_dot.sv =====
// Front end: dot product of incident and normal, clamp, index selection and
// the radicand 1 - cos^2 for the first square root. Depends on frf_pkg.
`default_nettype none

module frf_dot
    import frf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  fr_in_t      item,
    output logic        res_valid,
    output side_t       res_side,
    output logic [63:0] radicand
);

    localparam logic signed [DOT_W-1:0] POS_ONE = DOT_W'(64'sd1073741824);
    localparam logic signed [DOT_W-1:0] NEG_ONE = -POS_ONE;

    logic [2:0] valid_reg;

    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [PROD_W-1:0] px_next, py_next, pz_next;
    logic [15:0]              idx1_reg, idx2_reg;

    logic signed [DOT_W-1:0]  sum;
    logic signed [31:0]       dot_reg, dot_next;

    logic [31:0] mag;
    logic [61:0] csq;
    side_t       side_reg, side_next;
    logic [63:0] rad_reg, rad_next;

    assign px_next = $signed(item.incident_x[COMP_W-1:0]) * $signed(item.normal_x[COMP_W-1:0]);
    assign py_next = $signed(item.incident_y[COMP_W-1:0]) * $signed(item.normal_y[COMP_W-1:0]);
    assign pz_next = $signed(item.incident_z[COMP_W-1:0]) * $signed(item.normal_z[COMP_W-1:0]);

    always_comb
    begin
        sum = (DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg)) <<< PROD_SHIFT;
        if (sum > POS_ONE)
            dot_next = 32'(POS_ONE);
        else if (sum < NEG_ONE)
            dot_next = 32'(NEG_ONE);
        else
            dot_next = 32'(sum);
    end

    always_comb
    begin
        mag = (dot_reg < 0) ? 32'(-dot_reg) : 32'(dot_reg);
        csq = 62'(mag[30:0]) * 62'(mag[30:0]);
        side_next.c   = mag[30:0];
        // A ray that leaves the surface sees the two media swapped.
        side_next.ei  = (dot_reg > 0) ? idx2_reg : ONE_Q12;
        side_next.et  = (dot_reg > 0) ? ONE_Q12 : idx2_reg;
        side_next.bad = (idx2_reg == 16'd0);
        side_next.tir = 1'b0;
        rad_next      = ONE_Q60 - 64'(csq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[1:0], item_valid};
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        idx1_reg <= item.index_ratio;
        dot_reg  <= dot_next;
        idx2_reg <= idx1_reg;
        side_reg <= side_next;
        rad_reg  <= rad_next;
    end

    assign res_valid = valid_reg[2];
    assign res_side  = side_reg;
    assign radicand  = rad_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/frf_sqrt.sv =====
// Pipelined restoring square root, a fixed number of digits per stage.
// Depends on frf_pkg.
`default_nettype none

module frf_sqrt
    import frf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  side_t       op_side,
    input  logic [63:0] radicand,
    output logic        res_valid,
    output side_t       res_side,
    output logic [30:0] root
);

    logic [SQRT_STAGES-1:0] valid_reg;
    side_t     side_reg [SQRT_STAGES];
    sq_state_t st_reg   [SQRT_STAGES];
    sq_state_t st_next  [SQRT_STAGES];
    sq_state_t st_first;

    assign st_first = '{rad: radicand, rem: '0, root: '0};

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        sq_state_t st_in;
        sq_state_t st_work;
        if (k == 0)
        begin : g_first
            assign st_in = st_first;
        end
        else
        begin : g_rest
            assign st_in = st_reg[k-1];
        end
        always_comb
        begin
            st_work = st_in;
            for (int i = 0; i < STEPS_PER_STAGE; i++)
                st_work = sqrt_step(st_work);
        end
        assign st_next[k] = st_work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[SQRT_STAGES-2:0], op_valid};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= op_side;
        for (int k = 1; k < SQRT_STAGES; k++)
            side_reg[k] <= side_reg[k-1];
        for (int k = 0; k < SQRT_STAGES; k++)
            st_reg[k] <= st_next[k];
    end

    assign res_valid = valid_reg[SQRT_STAGES-1];
    assign res_side  = side_reg[SQRT_STAGES-1];
    assign root      = st_reg[SQRT_STAGES-1].root[30:0];

endmodule

`default_nettype wire

// ===== hw/rtl/frf_div.sv =====
// Pipelined divider for sint = sini * ei / et; the high part of the dividend
// is already below the divisor, so only 30 quotient bits remain. Uses frf_pkg.
`default_nettype none

module frf_div
    import frf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  side_t       op_side,
    input  logic [46:0] numer,
    output logic        res_valid,
    output side_t       res_side,
    output logic [29:0] quotient
);

    logic [DIV_STAGES-1:0] valid_reg;
    side_t      side_reg [DIV_STAGES];
    div_state_t st_reg   [DIV_STAGES];
    div_state_t st_next  [DIV_STAGES];
    div_state_t st_first;

    assign st_first = '{num: numer[29:0], rem: numer[45:30], q: '0};

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        div_state_t  st_in;
        div_state_t  st_work;
        logic [15:0] divisor;
        if (k == 0)
        begin : g_first
            assign st_in   = st_first;
            assign divisor = op_side.et;
        end
        else
        begin : g_rest
            assign st_in   = st_reg[k-1];
            assign divisor = side_reg[k-1].et;
        end
        always_comb
        begin
            st_work = st_in;
            for (int i = 0; i < STEPS_PER_STAGE; i++)
                st_work = div_step(st_work, divisor);
        end
        assign st_next[k] = st_work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[DIV_STAGES-2:0], op_valid};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= op_side;
        for (int k = 1; k < DIV_STAGES; k++)
            side_reg[k] <= side_reg[k-1];
        for (int k = 0; k < DIV_STAGES; k++)
            st_reg[k] <= st_next[k];
    end

    assign res_valid = valid_reg[DIV_STAGES-1];
    assign res_side  = side_reg[DIV_STAGES-1];
    assign quotient  = st_reg[DIV_STAGES-1].q;

endmodule

`default_nettype wire

// ===== hw/rtl/frf_frac.sv =====
// Pipelined fractional divider giving floor(n * 2^30 / d) in Q.30, or one
// when d is zero or n reaches d. Depends on frf_pkg.
`default_nettype none

module frf_frac
    import frf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    input  side_t       op_side,
    input  logic [46:0] numer,
    input  logic [46:0] denom,
    output logic        res_valid,
    output side_t       res_side,
    output logic [30:0] ratio
);

    logic [FRAC_STAGES-1:0] valid_reg;
    side_t       side_reg [FRAC_STAGES];
    frac_state_t st_reg   [FRAC_STAGES];
    frac_state_t st_next  [FRAC_STAGES];
    frac_state_t st_first;
    frac_state_t st_last;

    assign st_first = '{r: numer, d: denom, q: '0,
                        one: (denom == 47'd0) || (numer >= denom)};

    for (genvar k = 0; k < FRAC_STAGES; k++)
    begin : g_stage
        frac_state_t st_in;
        frac_state_t st_work;
        if (k == 0)
        begin : g_first
            assign st_in = st_first;
        end
        else
        begin : g_rest
            assign st_in = st_reg[k-1];
        end
        always_comb
        begin
            st_work = st_in;
            for (int i = 0; i < STEPS_PER_STAGE; i++)
                st_work = frac_step(st_work);
        end
        assign st_next[k] = st_work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[FRAC_STAGES-2:0], op_valid};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= op_side;
        for (int k = 1; k < FRAC_STAGES; k++)
            side_reg[k] <= side_reg[k-1];
        for (int k = 0; k < FRAC_STAGES; k++)
            st_reg[k] <= st_next[k];
    end

    assign st_last   = st_reg[FRAC_STAGES-1];
    assign res_valid = valid_reg[FRAC_STAGES-1];
    assign res_side  = side_reg[FRAC_STAGES-1];
    assign ratio     = st_last.one ? ONE_Q30 : {1'b0, st_last.q};

endmodule

`default_nettype wire

// ===== hw/rtl/fresnel_reflectance.sv =====
// Unpolarized Fresnel reflectance pipeline: one transaction per clock cycle.
// The path from the accepting edge to the done strobe is mostly set by the
// two 16-stage square roots and the 15-stage dividers at two bits per stage.
// busy is always low and the receiver cannot stall; done lasts one cycle.
// Reset clears all valid bits; items in flight are dropped.
`default_nettype none

module fresnel_reflectance
    import frf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  fr_in_t  item,
    output logic    done,
    output fr_out_t result
);

    logic        dot_valid;
    side_t       dot_side;
    logic [63:0] dot_rad;

    logic        sin_valid;
    side_t       sin_side;
    logic [30:0] sini;

    logic        tir_valid_reg;
    side_t       tir_side_reg, tir_side_next;
    logic [46:0] tir_num_reg, tir_num_next;

    logic        q_valid;
    side_t       q_side;
    logic [29:0] sint;

    logic        sq_valid_reg;
    side_t       sq_side_reg;
    logic [63:0] sq_rad_reg, sq_rad_next;

    logic        cos_valid;
    side_t       cos_side;
    logic [30:0] cost;

    logic        pr_valid_reg;
    side_t       pr_side_reg;
    logic [46:0] etc_reg, eic_reg, eicos_reg, etcos_reg;
    logic [46:0] etc_next, eic_next, eicos_next, etcos_next;

    logic        nd_valid_reg;
    side_t       nd_side_reg;
    logic [46:0] ns_reg, ds_reg, np_reg, dp_reg;
    logic [46:0] ns_next, ds_next, np_next, dp_next;

    logic        rs_valid, rp_valid;
    side_t       rs_side, rp_side;
    logic [30:0] rs, rp;

    logic        sqr_valid_reg;
    side_t       sqr_side_reg;
    logic [61:0] rs2_reg, rp2_reg, rs2_next, rp2_next;

    logic        done_reg;
    fr_out_t     result_reg, result_next;
    logic [62:0] sum;

    assign busy = 1'b0;

    frf_dot u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (start && !busy),
        .item       (item),
        .res_valid  (dot_valid),
        .res_side   (dot_side),
        .radicand   (dot_rad)
    );

    frf_sqrt u_sqrt_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (dot_valid),
        .op_side   (dot_side),
        .radicand  (dot_rad),
        .res_valid (sin_valid),
        .res_side  (sin_side),
        .root      (sini)
    );

    // Exact total internal reflection test: sini * ei >= 2^30 * et.
    always_comb
    begin
        tir_num_next      = 47'(sini) * 47'(sin_side.ei);
        tir_side_next     = sin_side;
        tir_side_next.tir = (tir_num_next >= {1'b0, sin_side.et, 30'd0});
    end

    frf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (tir_valid_reg),
        .op_side   (tir_side_reg),
        .numer     (tir_num_reg),
        .res_valid (q_valid),
        .res_side  (q_side),
        .quotient  (sint)
    );

    assign sq_rad_next = ONE_Q60 - 64'(60'(sint) * 60'(sint));

    frf_sqrt u_sqrt_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (sq_valid_reg),
        .op_side   (sq_side_reg),
        .radicand  (sq_rad_reg),
        .res_valid (cos_valid),
        .res_side  (cos_side),
        .root      (cost)
    );

    assign etc_next   = 47'(cos_side.et) * 47'(cos_side.c);
    assign eic_next   = 47'(cos_side.ei) * 47'(cos_side.c);
    assign eicos_next = 47'(cos_side.ei) * 47'(cost);
    assign etcos_next = 47'(cos_side.et) * 47'(cost);

    assign ns_next = (etc_reg >= eicos_reg) ? etc_reg - eicos_reg : eicos_reg - etc_reg;
    assign ds_next = etc_reg + eicos_reg;
    assign np_next = (eic_reg >= etcos_reg) ? eic_reg - etcos_reg : etcos_reg - eic_reg;
    assign dp_next = eic_reg + etcos_reg;

    frf_frac u_frac_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (nd_valid_reg),
        .op_side   (nd_side_reg),
        .numer     (ns_reg),
        .denom     (ds_reg),
        .res_valid (rs_valid),
        .res_side  (rs_side),
        .ratio     (rs)
    );

    frf_frac u_frac_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (nd_valid_reg),
        .op_side   (nd_side_reg),
        .numer     (np_reg),
        .denom     (dp_reg),
        .res_valid (rp_valid),
        .res_side  (rp_side),
        .ratio     (rp)
    );

    assign rs2_next = 62'(rs) * 62'(rs);
    assign rp2_next = 62'(rp) * 62'(rp);

    always_comb
    begin
        sum = 63'(rs2_reg) + 63'(rp2_reg);
        result_next.total_internal = 1'b0;
        result_next.bad_index      = 1'b0;
        if (sqr_side_reg.bad)
        begin
            result_next.reflectance = REFL_ONE;
            result_next.bad_index   = 1'b1;
        end
        else if (sqr_side_reg.tir)
        begin
            result_next.reflectance    = REFL_ONE;
            result_next.total_internal = 1'b1;
        end
        else
        begin
            result_next.reflectance = sum[61:46];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tir_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            nd_valid_reg  <= 1'b0;
            sqr_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            tir_valid_reg <= sin_valid;
            sq_valid_reg  <= q_valid;
            pr_valid_reg  <= cos_valid;
            nd_valid_reg  <= pr_valid_reg;
            sqr_valid_reg <= rs_valid;
            done_reg      <= sqr_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tir_side_reg <= tir_side_next;
        tir_num_reg  <= tir_num_next;
        sq_side_reg  <= q_side;
        sq_rad_reg   <= sq_rad_next;
        pr_side_reg  <= cos_side;
        etc_reg      <= etc_next;
        eic_reg      <= eic_next;
        eicos_reg    <= eicos_next;
        etcos_reg    <= etcos_next;
        nd_side_reg  <= pr_side_reg;
        ns_reg       <= ns_next;
        ds_reg       <= ds_next;
        np_reg       <= np_next;
        dp_reg       <= dp_next;
        sqr_side_reg <= rs_side;
        rs2_reg      <= rs2_next;
        rp2_reg      <= rp2_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transaction did not complete after the pipeline latency");

    a_lanes : assert property (@(posedge clk) disable iff (!rst_n)
        (rs_valid == rp_valid) && (!rs_valid || (rs_side == rp_side)))
        else $error("Rs and Rp dividers out of step");

    a_flags : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.bad_index || result.total_internal)) |->
        ((result.reflectance == REFL_ONE) && !(result.bad_index && result.total_internal)))
        else $error("flagged result without unit reflectance");

    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.reflectance <= REFL_ONE))
        else $error("reflectance above one");
`endif

endmodule

`default_nettype wire
